>>> rtl/cftq_pkg.sv
// Shared types, widths and constants of the CAN frame transmit queue.
`default_nettype none
package cftq_pkg;

    localparam int ID_W      = 11;
    localparam int REQ_LEN_W = 8;
    localparam int LEN_W     = 4;
    localparam int DATA_W    = 64;
    localparam int OFFER_W   = 2;
    localparam int DEPTH_W   = 5;
    localparam int DROP_W    = 16;
    localparam int BYTES     = DATA_W / 8;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int MAILBOX_COUNT_DEF = 3;
    localparam int CMDQ_DEPTH        = 2;

    localparam logic [LEN_W-1:0] MAX_LENGTH = 4'd8;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_PUMP    = 1'b1
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_back_state;

    // Classified command from the front end.
    typedef struct packed {
        t_action             action;
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic [DATA_W-1:0]   data;
        logic [OFFER_W-1:0]  offer;
    } t_cmd;

    // One queued frame as held in the frame memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_frame;

    localparam int FRAME_W = $bits(t_frame);

    typedef struct packed {
        logic                is_frame;
        logic                accepted;
        logic [ID_W-1:0]     frame_id;
        logic [LEN_W-1:0]    frame_length;
        logic [DATA_W-1:0]   frame_data;
        logic                last;
        logic [DEPTH_W-1:0]  depth;
        logic [DROP_W-1:0]   dropped_count;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/cftq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cftq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/cftq_front.sv
// Front end: takes input items, clamps length, masks payload, queues commands.
`default_nettype none
module cftq_front
    import cftq_pkg::*;
#(
    parameter int MAILBOX_COUNT = MAILBOX_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_action,
    input  wire logic [ID_W-1:0]      i_std_id,
    input  wire logic [REQ_LEN_W-1:0] i_req_length,
    input  wire logic [DATA_W-1:0]    i_payload,
    input  wire logic [OFFER_W-1:0]   i_free_mailboxes,
    output logic                      o_cmd_valid,
    output t_cmd                      o_cmd,
    input  wire logic                 i_cmd_pop
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_q [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             cmd_in;
    logic [LEN_W-1:0] len_c;
    logic             push;

    // Classify and condition the incoming item.
    always_comb begin
        len_c = (i_req_length > REQ_LEN_W'(MAX_LENGTH)) ? MAX_LENGTH
                                                        : i_req_length[LEN_W-1:0];
        cmd_in.action = t_action'(i_action);
        cmd_in.id     = i_std_id;
        cmd_in.len    = len_c;
        for (int i = 0; i < BYTES; i++) begin
            cmd_in.data[8*i +: 8] = (LEN_W'(i) < len_c) ? i_payload[8*i +: 8] : 8'd0;
        end
        // offer beyond the mailbox count saturates
        cmd_in.offer = (int'(i_free_mailboxes) > MAILBOX_COUNT)
                     ? OFFER_W'(MAILBOX_COUNT) : i_free_mailboxes;
    end

    assign o_ready     = (r_cnt != CNT_W'(CMDQ_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ((r_wp == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1)) : r_wp;
        n_rp  = i_cmd_pop ? ((r_rp == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1))
                          : r_rp;
        n_cnt = r_cnt + CNT_W'(push) - CNT_W'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

>>> rtl/cftq_back.sv
// Back end: ring-buffer bookkeeping, frame memory access and result register.
`default_nettype none
module cftq_back
    import cftq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    input  wire t_cmd  i_cmd,
    output logic       o_cmd_pop,
    output logic       o_res_valid,
    output t_result    o_res,
    input  wire logic  i_res_ready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    t_back_state        r_state, n_state;
    logic [IDX_W-1:0]   r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [DROP_W-1:0]  r_drop, n_drop;
    logic [OFFER_W-1:0] r_remain, n_remain;
    logic               r_valid, n_valid;
    t_result            r_res, n_res;

    logic               out_free;
    logic               full;
    logic [OFFER_W-1:0] sends;
    logic               ram_we;
    logic               ram_re;
    t_frame             wr_frame;
    t_frame             rd_frame;

    cftq_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (wr_frame),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_frame)
    );

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    assign out_free = !r_valid || i_res_ready;
    assign full     = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign sends    = (r_occ < OCC_W'(i_cmd.offer)) ? OFFER_W'(r_occ) : i_cmd.offer;
    assign wr_frame = '{id: i_cmd.id, len: i_cmd.len, data: i_cmd.data};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free && i_cmd.action == ACT_PUMP && sends != '0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free && r_remain == OFFER_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and control outputs.
    always_comb begin
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_occ     = r_occ;
        n_drop    = r_drop;
        n_remain  = r_remain;
        n_valid   = r_valid && !i_res_ready;
        n_res     = r_res;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    n_res     = '0;
                    n_res.last = 1'b1;
                    if (i_cmd.action == ACT_ENQUEUE) begin
                        n_valid = 1'b1;
                        if (full) begin
                            n_drop = r_drop + DROP_W'(1);
                        end else begin
                            ram_we         = 1'b1;
                            n_wr_idx       = f_next(r_wr_idx);
                            n_occ          = r_occ + OCC_W'(1);
                            n_res.accepted = 1'b1;
                        end
                    end else if (sends == '0) begin
                        n_valid = 1'b1;
                    end else begin
                        ram_re   = 1'b1;
                        n_rd_idx = f_next(r_rd_idx);
                        n_remain = sends;
                    end
                    n_res.depth         = DEPTH_W'(n_occ);
                    n_res.dropped_count = n_drop;
                end
            end
            ST_READ: begin
                // rd_frame holds the frame of the most recent frame-memory read
                if (out_free) begin
                    n_valid             = 1'b1;
                    n_occ               = r_occ - OCC_W'(1);
                    n_remain            = r_remain - OFFER_W'(1);
                    n_res.is_frame      = 1'b1;
                    n_res.accepted      = 1'b0;
                    n_res.frame_id      = rd_frame.id;
                    n_res.frame_length  = rd_frame.len;
                    n_res.frame_data    = rd_frame.data;
                    n_res.last          = (r_remain == OFFER_W'(1));
                    n_res.depth         = DEPTH_W'(n_occ);
                    n_res.dropped_count = r_drop;
                    if (r_remain != OFFER_W'(1)) begin
                        ram_re   = 1'b1;
                        n_rd_idx = f_next(r_rd_idx);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_occ    <= '0;
            r_drop   <= '0;
            r_remain <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_occ    <= n_occ;
            r_drop   <= n_drop;
            r_remain <= n_remain;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

>>> rtl/can_frame_transmit_queue.sv
// Top level of the CAN frame transmit queue: front end, command queue, back end.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_ready  | action, std_id, req_length, payload,
//          |           |                    | free_mailboxes
//  result  | out       | o_valid / i_ready  | is_frame, accepted, frame_id, frame_length,
//          |           |                    | frame_data, last, depth, dropped_count
//
// Flow: an accepted transfer is registered in a two-entry command queue, which the
// back end pops. An enqueue or an idle pump result is then registered in the result
// register. A pump first reads its first frame from the frame memory, then returns
// one frame per cycle while the result is not held, bounded by the single read port;
// its first frame follows the command queue, the frame memory and the result register.
// Reset: synchronous, active low; clears pointers, occupancy and drop count.
// The frame memory needs no clearing, since only written entries are read.
// Stalls: a held result stalls only the back end; the front end keeps taking
// transfers until the command queue is full.
`default_nettype none
module can_frame_transmit_queue
    import cftq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int MAILBOX_COUNT = MAILBOX_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_action,
    input  wire logic [ID_W-1:0]      i_std_id,
    input  wire logic [REQ_LEN_W-1:0] i_req_length,
    input  wire logic [DATA_W-1:0]    i_payload,
    input  wire logic [OFFER_W-1:0]   i_free_mailboxes,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_is_frame,
    output logic                      o_accepted,
    output logic      [ID_W-1:0]      o_frame_id,
    output logic      [LEN_W-1:0]     o_frame_length,
    output logic      [DATA_W-1:0]    o_frame_data,
    output logic                      o_last,
    output logic      [DEPTH_W-1:0]   o_depth,
    output logic      [DROP_W-1:0]    o_dropped_count
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    t_result res;

    // Front end: clamp length, zero unused bytes, saturate mailbox offer.
    cftq_front #(
        .MAILBOX_COUNT (MAILBOX_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_std_id         (i_std_id),
        .i_req_length     (i_req_length),
        .i_payload        (i_payload),
        .i_free_mailboxes (i_free_mailboxes),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_pop        (cmd_pop)
    );

    // Back end: ring buffer, drop counter, frame memory and result register.
    cftq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_valid),
        .o_res       (res),
        .i_res_ready (i_ready)
    );

    assign o_is_frame      = res.is_frame;
    assign o_accepted      = res.accepted;
    assign o_frame_id      = res.frame_id;
    assign o_frame_length  = res.frame_length;
    assign o_frame_data    = res.frame_data;
    assign o_last          = res.last;
    assign o_depth         = res.depth;
    assign o_dropped_count = res.dropped_count;

    // A sent frame never claims an accepted enqueue.
    a_frame_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_frame |-> !o_accepted)
        else $error("frame result flagged as accepted enqueue");

    // Stored length is always clamped.
    a_length_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_frame |-> o_frame_length <= MAX_LENGTH)
        else $error("frame length above maximum");

    // A pump burst streams without gaps: a non-final frame is followed at once
    // by the next frame of the same burst.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_is_frame && !o_last |=> o_valid && o_is_frame)
        else $error("pump burst broken before last frame");

    // Non-frame results always close their item.
    a_single_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_frame |-> o_last)
        else $error("enqueue or idle result without last");

endmodule
`default_nettype wire
